// ===== src/ctstw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ctstw_pkg;

  // Preset registers: six of them, 10 bits each, in minutes.
  localparam int unsigned NUM_PRESETS  = 6;
  localparam int unsigned PRESET_SLOTS = 6;
  localparam int unsigned PRESET_W     = 10;
  localparam int unsigned SLOT_W       = 3;
  localparam int unsigned MS_W         = 32;
  localparam int unsigned CFG_ADDR_W   = 5;
  localparam int unsigned CFG_DATA_W   = 32;

  // Widths of the intermediate time values in the formatter.
  localparam int unsigned TSEC_W = 23;  // seconds, at most 4294967
  localparam int unsigned TMIN_W = 17;  // minutes, at most 71582
  localparam int unsigned THRS_W = 11;  // hours, at most 1193

  localparam logic [MS_W-1:0]   MS_PER_SEC = 32'd1000;
  localparam logic [15:0]       MS_PER_MIN = 16'd60000;
  localparam logic [MS_W-1:0]   HOURS_FORMAT_MS = 32'd6000000;
  localparam logic [TMIN_W-1:0] HOURS_FORMAT_MIN = 17'd100;
  localparam logic [THRS_W-1:0] HOURS_MAX = 11'd99;

  // Reciprocal constants for the divisions by 1000 and by 60.
  localparam logic [31:0] RECIP_1000     = 32'd2199023256;  // ceil(2^41 / 1000)
  localparam int unsigned RECIP_1000_SH  = 41;
  localparam logic [23:0] RECIP_60_SEC   = 24'd8947849;     // ceil(2^29 / 60)
  localparam int unsigned RECIP_60_SEC_SH = 29;
  localparam logic [17:0] RECIP_60_MIN   = 18'd139811;      // ceil(2^23 / 60)
  localparam int unsigned RECIP_60_MIN_SH = 23;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] KIND_POLL   = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_ENTER  = 2'd2;

  // Button codes.
  localparam logic [2:0] BTN_BACK    = 3'd0;
  localparam logic [2:0] BTN_LEFT    = 3'd1;
  localparam logic [2:0] BTN_RIGHT   = 3'd2;
  localparam logic [2:0] BTN_UP      = 3'd3;
  localparam logic [2:0] BTN_DOWN    = 3'd4;
  localparam logic [2:0] BTN_CONFIRM = 3'd5;
  localparam logic [2:0] BTN_NONE    = 3'd7;

  // Phase codes as they appear on the result.
  localparam logic [1:0] PHASE_SETUP   = 2'd0;
  localparam logic [1:0] PHASE_RUNNING = 2'd1;
  localparam logic [1:0] PHASE_PAUSED  = 2'd2;
  localparam logic [1:0] PHASE_DONE    = 2'd3;

  localparam logic [SLOT_W-1:0] DEFAULT_SLOT = 3'd3;

  typedef logic [PRESET_W-1:0] preset_arr_t [NUM_PRESETS];

  localparam preset_arr_t PRESET_RESET = '{10'd5, 10'd10, 10'd15, 10'd25, 10'd45, 10'd60};

  // Result of the state update, before formatting.
  typedef struct packed {
    logic [1:0]        phase;
    logic              mode;
    logic [SLOT_W-1:0] slot;
    logic [MS_W-1:0]   shown;
    logic              done;
    logic              leave;
    logic              redraw;
  } res_t;

  // Fully formatted result.
  typedef struct packed {
    logic [1:0]        phase;
    logic              mode;
    logic [SLOT_W-1:0] slot;
    logic [MS_W-1:0]   shown;
    logic [6:0]        clock_high;
    logic [5:0]        clock_low;
    logic              is_hours;
    logic              done;
    logic              leave;
    logic              redraw;
  } out_t;

endpackage

`default_nettype wire

// ===== src/ctstw_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctstw_cfg
  import ctstw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output preset_arr_t           preset
);

  logic [2:0] reg_idx;
  logic       idx_ok;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign idx_ok  = (32'(reg_idx) < NUM_PRESETS);
  assign wr_en   = psel && penable && pwrite && idx_ok;
  assign pready  = 1'b1;

  // Preset registers, written on the access cycle of a write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      preset <= PRESET_RESET;
    end else if (wr_en) begin
      preset[reg_idx] <= pwdata[PRESET_W-1:0];
    end
  end

  // Read data; addresses beyond the register list read as zero.
  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = CFG_DATA_W'(preset[reg_idx]);
    end
  end

endmodule

`default_nettype wire

// ===== src/ctstw_state.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctstw_state
  import ctstw_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = PRESET_SLOTS
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [2:0]        button,
  input  logic [MS_W-1:0]   now_ms,
  input  preset_arr_t       preset,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  typedef enum logic [3:0] {
    PH_SETUP   = 4'b0001,
    PH_RUNNING = 4'b0010,
    PH_PAUSED  = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  localparam logic [MS_W-1:0] RESET_REMAINING =
    MS_W'(PRESET_RESET[DEFAULT_SLOT]) * MS_W'(MS_PER_MIN);

  // Countdown length of a slot; slots outside the selectable range fall back to slot 0.
  function automatic logic [MS_W-1:0] slot_dur(input preset_arr_t p, input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] idx;
    idx = s;
    if ((32'(s) >= SLOT_COUNT) || (32'(s) >= NUM_PRESETS)) begin
      idx = '0;
    end
    return MS_W'(p[idx]) * MS_W'(MS_PER_MIN);
  endfunction

  function automatic logic [1:0] phase_code(input phase_t p);
    logic [1:0] c;
    unique case (p)
      PH_SETUP:   c = PHASE_SETUP;
      PH_RUNNING: c = PHASE_RUNNING;
      PH_PAUSED:  c = PHASE_PAUSED;
      PH_DONE:    c = PHASE_DONE;
      default:    c = PHASE_SETUP;
    endcase
    return c;
  endfunction

  phase_t            phase_reg, phase_next;
  logic              mode_reg, mode_next;
  logic [SLOT_W-1:0] slot_reg, slot_next;
  logic [MS_W-1:0]   remaining_ms, rem_next;
  logic [MS_W-1:0]   elapsed_ms, ela_next;
  logic [MS_W-1:0]   completion_ms, comp_next;
  logic [MS_W-1:0]   last_tick_ms, last_next;

  logic              accept;
  logic [2:0]        btn;
  logic [MS_W-1:0]   delta;
  logic              adv_fin;
  logic [MS_W-1:0]   adv_rem;
  logic [MS_W-1:0]   adv_ela;
  logic [MS_W-1:0]   dur_cur;
  logic [SLOT_W-1:0] slot_step;
  logic [MS_W-1:0]   dur_step;
  logic              redraw, leave, done;
  logic [MS_W-1:0]   shown;

  assign accept   = in_valid && in_ready;
  assign in_ready = !res_valid || res_ready;

  // A poll behaves as the release of no button.
  assign btn = (kind == KIND_POLL) ? BTN_NONE : button;

  // Time advance of the running phase: wrapped difference to the last tick.
  assign delta   = now_ms - last_tick_ms;
  assign adv_fin = !mode_reg && (delta != '0) && (delta >= remaining_ms);
  assign adv_rem = mode_reg ? remaining_ms : (remaining_ms - delta);
  assign adv_ela = elapsed_ms + delta;
  assign dur_cur = slot_dur(preset, slot_reg);

  // Clamped preset stepping.
  always_comb begin
    slot_step = slot_reg;
    if (btn == BTN_UP) begin
      if ((32'(slot_reg) + 32'd1) < SLOT_COUNT) begin
        slot_step = slot_reg + 1'b1;
      end
    end else if (slot_reg != '0) begin
      slot_step = slot_reg - 1'b1;
    end
  end

  assign dur_step = slot_dur(preset, slot_step);

  // Next state for one item.
  always_comb begin
    phase_next = phase_reg;
    mode_next  = mode_reg;
    slot_next  = slot_reg;
    rem_next   = remaining_ms;
    ela_next   = elapsed_ms;
    comp_next  = completion_ms;
    last_next  = last_tick_ms;
    redraw     = 1'b0;
    leave      = 1'b0;
    done       = 1'b0;

    if (kind == KIND_ENTER) begin
      mode_next  = 1'b0;
      phase_next = PH_SETUP;
      slot_next  = DEFAULT_SLOT;
      rem_next   = slot_dur(preset, DEFAULT_SLOT);
      ela_next   = '0;
      comp_next  = '0;
      last_next  = '0;
      redraw     = 1'b1;
    end else if ((kind == KIND_POLL) || (kind == KIND_BUTTON)) begin
      if (btn == BTN_BACK) begin
        if ((phase_reg == PH_SETUP) || (phase_reg == PH_DONE)) begin
          leave = 1'b1;
        end else if ((phase_reg == PH_RUNNING) && adv_fin) begin
          rem_next   = '0;
          ela_next   = dur_cur;
          comp_next  = dur_cur;
          last_next  = now_ms;
          phase_next = PH_DONE;
          redraw     = 1'b1;
        end else begin
          // Complete from the current (advanced, when running) times.
          if (phase_reg == PH_RUNNING) begin
            rem_next  = adv_rem;
            ela_next  = adv_ela;
            last_next = now_ms;
            comp_next = mode_reg ? adv_ela : (dur_cur - adv_rem);
          end else begin
            comp_next = mode_reg ? elapsed_ms : (dur_cur - remaining_ms);
          end
          phase_next = PH_DONE;
          redraw     = 1'b1;
        end
      end else if (phase_reg == PH_SETUP) begin
        if ((btn == BTN_LEFT) || (btn == BTN_RIGHT)) begin
          mode_next = (btn == BTN_RIGHT);
          rem_next  = dur_cur;
          redraw    = 1'b1;
        end else if (!mode_reg && ((btn == BTN_UP) || (btn == BTN_DOWN))) begin
          slot_next = slot_step;
          rem_next  = dur_step;
          redraw    = 1'b1;
        end else if (btn == BTN_CONFIRM) begin
          rem_next   = dur_cur;
          ela_next   = '0;
          comp_next  = '0;
          last_next  = now_ms;
          phase_next = PH_RUNNING;
          redraw     = 1'b1;
        end
      end else if (phase_reg == PH_DONE) begin
        if (btn == BTN_CONFIRM) begin
          rem_next   = dur_cur;
          ela_next   = '0;
          comp_next  = '0;
          last_next  = now_ms;
          phase_next = PH_RUNNING;
          redraw     = 1'b1;
        end
      end else if (btn == BTN_CONFIRM) begin
        if (phase_reg == PH_RUNNING) begin
          if (adv_fin) begin
            rem_next   = '0;
            ela_next   = dur_cur;
            comp_next  = dur_cur;
            phase_next = PH_DONE;
            last_next  = now_ms;
          end else begin
            rem_next   = adv_rem;
            ela_next   = adv_ela;
            phase_next = PH_PAUSED;
            last_next  = '0;
          end
        end else begin
          phase_next = PH_RUNNING;
          last_next  = now_ms;
        end
        redraw = 1'b1;
      end else if (btn == BTN_LEFT) begin
        rem_next   = dur_cur;
        ela_next   = '0;
        comp_next  = '0;
        last_next  = '0;
        phase_next = PH_PAUSED;
        redraw     = 1'b1;
      end else if ((phase_reg == PH_RUNNING) && (delta >= MS_PER_SEC)) begin
        // A poll or an idle button advances time once a second has passed.
        if (adv_fin) begin
          rem_next   = '0;
          ela_next   = dur_cur;
          comp_next  = dur_cur;
          phase_next = PH_DONE;
        end else begin
          rem_next = adv_rem;
          ela_next = adv_ela;
        end
        last_next = now_ms;
        redraw    = 1'b1;
      end
      done = (phase_next == PH_DONE) && (phase_reg != PH_DONE);
    end
  end

  // Time on show after this item.
  always_comb begin
    if (phase_next == PH_DONE) begin
      shown = comp_next;
    end else begin
      shown = mode_next ? ela_next : rem_next;
    end
  end

  // Timer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_SETUP;
      mode_reg      <= 1'b0;
      slot_reg      <= DEFAULT_SLOT;
      remaining_ms  <= RESET_REMAINING;
      elapsed_ms    <= '0;
      completion_ms <= '0;
      last_tick_ms  <= '0;
    end else if (accept) begin
      phase_reg     <= phase_next;
      mode_reg      <= mode_next;
      slot_reg      <= slot_next;
      remaining_ms  <= rem_next;
      elapsed_ms    <= ela_next;
      completion_ms <= comp_next;
      last_tick_ms  <= last_next;
    end
  end

  // Result register towards the formatter.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.phase  <= phase_code(phase_next);
      res.mode   <= mode_next;
      res.slot   <= slot_next;
      res.shown  <= shown;
      res.done   <= done;
      res.leave  <= leave;
      res.redraw <= redraw;
    end
  end

`ifndef ASSERT_OFF
  // The selected slot always stays within the selectable range.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    32'(slot_reg) < SLOT_COUNT)
    else $error("preset slot out of range");

  // An enter event leaves the timer in setup on the default slot with a redraw.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    accept && (kind == KIND_ENTER) |=>
      (phase_reg == PH_SETUP) && (slot_reg == DEFAULT_SLOT) && !mode_reg &&
      res.redraw && (res.phase == PHASE_SETUP))
    else $error("enter event did not reinitialise the timer");

  // Without an accepted item the timer state holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase_reg) && $stable(remaining_ms) && $stable(elapsed_ms) &&
      $stable(last_tick_ms))
    else $error("timer state changed without a transfer");
`endif

endmodule

`default_nettype wire

// ===== src/ctstw_fmt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctstw_fmt
  import ctstw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic res_valid,
  output logic res_ready,
  input  res_t res,
  output logic o_valid,
  input  logic o_ready,
  output out_t o
);

  // Stage 2: seconds. Stage 3: minutes. Stage 4: seconds field and hours.
  // Stage 5: output register with the final mm:ss or hh:mm selection.
  logic v2, v3, v4;
  logic r2, r3, r4, r5;

  res_t              res2, res3, res4;
  logic [TSEC_W-1:0] tsec2, tsec3;
  logic [TMIN_W-1:0] tmin3, tmin4;
  logic [5:0]        sec4;
  logic [THRS_W-1:0] thrs4;

  logic [63:0]           prod_sec;
  logic [46:0]           prod_min;
  logic [34:0]           prod_hrs;
  logic [TSEC_W-1:0]     sec_diff;
  logic [TMIN_W-1:0]     min_diff;
  logic                  is_hours;
  logic [6:0]            hrs_sat;

  // Each stage takes new data when it is empty or its successor takes its data.
  assign r5 = !o_valid || o_ready;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign res_ready = r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (r2) v2 <= res_valid;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) o_valid <= v4;
    end
  end

  // Whole seconds by reciprocal multiplication.
  assign prod_sec = 64'(res.shown) * 64'(RECIP_1000);

  always_ff @(posedge clk) begin
    if (r2 && res_valid) begin
      res2  <= res;
      tsec2 <= prod_sec[RECIP_1000_SH +: TSEC_W];
    end
  end

  // Whole minutes.
  assign prod_min = 47'(tsec2) * 47'(RECIP_60_SEC);

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      res3  <= res2;
      tsec3 <= tsec2;
      tmin3 <= prod_min[RECIP_60_SEC_SH +: TMIN_W];
    end
  end

  // Seconds within the minute, and whole hours.
  assign sec_diff = tsec3 - (TSEC_W'(tmin3) * TSEC_W'(60));
  assign prod_hrs = 35'(tmin3) * 35'(RECIP_60_MIN);

  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      res4  <= res3;
      tmin4 <= tmin3;
      sec4  <= sec_diff[5:0];
      thrs4 <= prod_hrs[RECIP_60_MIN_SH +: THRS_W];
    end
  end

  // Minutes within the hour and the choice of format.
  assign min_diff = tmin4 - (TMIN_W'(thrs4) * TMIN_W'(60));
  assign is_hours = (tmin4 >= HOURS_FORMAT_MIN);
  assign hrs_sat  = (thrs4 > HOURS_MAX) ? HOURS_MAX[6:0] : thrs4[6:0];

  always_ff @(posedge clk) begin
    if (r5 && v4) begin
      o.phase      <= res4.phase;
      o.mode       <= res4.mode;
      o.slot       <= res4.slot;
      o.shown      <= res4.shown;
      o.clock_high <= is_hours ? hrs_sat : tmin4[6:0];
      o.clock_low  <= is_hours ? min_diff[5:0] : sec4;
      o.is_hours   <= is_hours;
      o.done       <= res4.done;
      o.leave      <= res4.leave;
      o.redraw     <= res4.redraw;
    end
  end

`ifndef ASSERT_OFF
  // Clock fields stay within their display ranges.
  a_clock_range: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o.clock_low < 6'd60) && (o.clock_high <= 7'd99))
    else $error("clock field out of range");

  // The hours format is chosen exactly from 100 minutes upwards.
  a_hours_fmt: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o.is_hours == (o.shown >= HOURS_FORMAT_MS)))
    else $error("clock format does not match the shown time");

  // In mm:ss format the fields give the shown time truncated to whole seconds.
  a_mmss: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o.is_hours |->
      ((32'(o.clock_high) * 32'd60000 + 32'(o.clock_low) * MS_PER_SEC) <= o.shown) &&
      (o.shown < (32'(o.clock_high) * 32'd60000 + 32'(o.clock_low) * MS_PER_SEC +
                  MS_PER_SEC)))
    else $error("mm:ss fields do not match the shown time");
`endif

endmodule

`default_nettype wire

// ===== src/countdown_stopwatch_timer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Transfer carries
// s_axis    in         tuser: kind; tdata: button, now_ms
// m_axis    out        tuser: stopwatch_mode, clock_is_hours; tdata: remaining fields
// apb       in         preset_minutes_0..5 at byte addresses 0, 4, ... 20
//
// One input item is taken every cycle while the result path is not stalled; the timer state updates in the cycle of the
// transfer, so consecutive items see each other's effect without a gap.
// A result becomes valid on m_axis after its input transfer: the transfer edge updates the
// state and registers the result, then each formatter stage registers it in turn
// (divide by 1000, by 60, by 60, selection).
// rst is synchronous and clears the timer to setup, countdown, slot 3 and all presets to
// their defaults. A stalled m_axis fills the pipeline stage by stage before s_tready falls.

module countdown_stopwatch_timer_core
  import ctstw_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = PRESET_SLOTS
)
(
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [39:0]           s_tdata,  // [2:0] button, [34:3] now_ms, [39:35] zero
  input  logic [1:0]            s_tuser,  // [1:0] kind
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata,  // [1:0] phase, [4:2] preset_slot, [36:5] shown_ms,
                                          // [43:37] clock_high, [49:44] clock_low,
                                          // [50] just_completed, [51] leave_request,
                                          // [52] redraw, [55:53] zero
  output logic [1:0]            m_tuser,  // [0] stopwatch_mode, [1] clock_is_hours
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  preset_arr_t preset;
  logic        res_valid;
  logic        res_ready;
  res_t        res;
  out_t        o;

  ctstw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .preset  (preset)
  );

  ctstw_state #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_state (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .kind      (s_tuser),
    .button    (s_tdata[2:0]),
    .now_ms    (s_tdata[34:3]),
    .preset    (preset),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ctstw_fmt u_fmt (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .o_valid   (m_tvalid),
    .o_ready   (m_tready),
    .o         (o)
  );

  // Pack the result fields, lowest field in the lowest bits.
  assign m_tdata = {3'b000, o.redraw, o.leave, o.done, o.clock_low, o.clock_high,
                    o.shown, o.slot, o.phase};
  assign m_tuser = {o.is_hours, o.mode};

endmodule

`default_nettype wire
